// ===== design/sct_pkg.sv =====
// ============================================================================
// sct_pkg: shared types, constants and arithmetic helpers
// Fixed-point helpers for the series sine/cosine pipeline (Q5.26 in,
// Q8.40 inside, Q3.29 out) and the reciprocal-factorial coefficient table.
// ============================================================================
package sct_pkg;

    // Number of alternating terms in each series.
    localparam int SERIES_TERMS = 8;
    // Horner steps after the leading coefficient.
    localparam int HORNER_STEPS = SERIES_TERMS - 1;

    // 2*pi rounded to Q5.26, and the range reduction by repeated halving of
    // a multiple of it. The offset makes every sign-extended angle positive.
    localparam int RED_WIDTH = 33;
    localparam int RED_STEPS = 4;
    localparam logic [RED_WIDTH-1:0] TWO_PI_Q26 = 33'd421657428;
    localparam logic [RED_WIDTH-1:0] RED_OFFSET = 33'd2529944568;
    localparam int ANG_WIDTH = 29;

    // Register stages: input, reduction, square, rounding, three per Horner
    // step, three for the final sine product, output conversion.
    localparam int PIPE_DEPTH = 11 + 3 * HORNER_STEPS;

    localparam logic [47:0] Q40_LIM = 48'h8000_0000_0000;
    localparam logic signed [47:0] Q40_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] Q40_MIN = 48'sh8000_0000_0000;
    localparam logic [95:0] Q40_HALF = 96'h80_0000_0000;

    // round(2^40 / n!) with ties up; zero from n = 16 on.
    localparam int COEF_DEPTH = 24;
    localparam logic [47:0] RECIP_FACT [0:COEF_DEPTH-1] = '{
        48'd1099511627776, 48'd1099511627776, 48'd549755813888,
        48'd183251937963,  48'd45812984491,   48'd9162596898,
        48'd1527099483,    48'd218157069,     48'd27269634,
        48'd3029959,       48'd302996,        48'd27545,
        48'd2295,          48'd177,           48'd13,
        48'd1,             48'd0,             48'd0,
        48'd0,             48'd0,             48'd0,
        48'd0,             48'd0,             48'd0
    };

    // Four 24x24 partial products of two magnitudes and the product sign.
    typedef struct packed {
        logic        neg;
        logic [47:0] ll;
        logic [47:0] lh;
        logic [47:0] hl;
        logic [47:0] hh;
    } pp_t;

    function automatic logic [47:0] mag48(input logic signed [47:0] v);
        return v[47] ? 48'(-v) : 48'(v);
    endfunction

    function automatic pp_t pp_calc(input logic [47:0] a, input logic [47:0] b,
                                    input logic neg);
        pp_t p;
        p.neg = neg;
        p.ll  = 48'(a[23:0])  * 48'(b[23:0]);
        p.lh  = 48'(a[23:0])  * 48'(b[47:24]);
        p.hl  = 48'(a[47:24]) * 48'(b[23:0]);
        p.hh  = 48'(a[47:24]) * 48'(b[47:24]);
        return p;
    endfunction

    // Full product plus the rounding half of the Q8.40 scaling.
    function automatic logic [95:0] pp_sum(input pp_t p);
        return (96'(p.hh) << 48) + ((96'(p.lh) + 96'(p.hl)) << 24)
               + 96'(p.ll) + Q40_HALF;
    endfunction

    // Scale the rounded product back to Q8.40, apply the sign and saturate.
    function automatic logic signed [47:0] mul_finish(input logic [95:0] prod,
                                                      input logic neg);
        logic [55:0] q;
        logic [47:0] r;
        q = prod[95:40];
        r = (q > 56'(Q40_LIM)) ? Q40_LIM : q[47:0];
        if (neg)
            return $signed(48'(-r));
        else if (r == Q40_LIM)
            return Q40_MAX;
        else
            return $signed(r);
    endfunction

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        if (v > 50'(Q40_MAX))
            return Q40_MAX;
        else if (v < 50'(Q40_MIN))
            return Q40_MIN;
        else
            return v[47:0];
    endfunction

    // Q8.40 to Q3.29, rounding half away from zero, 32-bit saturation.
    function automatic logic [31:0] to_q29(input logic signed [47:0] v);
        logic [36:0] m;
        m = 37'((49'(mag48(v)) + 49'd1024) >> 11);
        if (!v[47])
            return (m > 37'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
        else
            return (m > 37'h0_8000_0000) ? 32'h8000_0000 : 32'(-m[31:0]);
    endfunction

endpackage

// ===== design/sin_cos_taylor_series_unit.sv =====
// ============================================================================
// sin_cos_taylor_series_unit: pipelined series sine and cosine
// Reduces a Q5.26 angle modulo 2*pi, evaluates eight-term Maclaurin series
// for sine and cosine by Horner's rule in x*x, one angle per unstalled cycle.
// ============================================================================
// Usage:
// The angle channel (angle_valid, angle_stall, angle) takes one signed Q5.26
// angle per beat. The result channel (result_valid, result_stall, sine,
// cosine) returns both Q3.29 values of that angle in one beat, in order.
// A new angle can enter every cycle while angle_stall is low, so throughput
// is one beat per cycle. The pipeline holds one input stage, four reduction
// stages, two for x*x, three for each of the seven Horner steps (24x24
// partial products, their sum, and one round/subtract stage), three for the
// final sine product and one for output rounding, then the output register.
// When the receiver stalls, the output register holds its beat and the
// pipeline keeps advancing until one more finished beat lands in a skid
// register; then angle_stall rises and the whole pipeline freezes in place.
// angle_stall comes straight from a register.
// Reset clears every valid bit, those of the output and skid registers too.
// ============================================================================
module sin_cos_taylor_series_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        angle_valid,
    output logic        angle_stall,
    input  logic [31:0] angle,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] sine,
    output logic [31:0] cosine
);

    localparam int NSTEP = sct_pkg::HORNER_STEPS;
    localparam int DEPTH = sct_pkg::PIPE_DEPTH;
    localparam int RW    = sct_pkg::ANG_WIDTH;

    logic                   adv;
    logic [DEPTH-1:0]       vld_reg;

    logic [sct_pkg::RED_WIDTH-1:0] red_reg [0:sct_pkg::RED_STEPS];
    logic [2*RW-1:0]        rr_reg;
    logic [RW-1:0]          r5_reg;
    logic [47:0]            x2_reg;
    logic [RW-1:0]          r6_reg;

    // Horner step inputs: index 0 is the leading coefficient, index j+1 the
    // result of step j.
    logic signed [47:0]     sacc_w [0:NSTEP];
    logic signed [47:0]     cacc_w [0:NSTEP];
    logic [47:0]            x2_w   [0:NSTEP];
    logic [RW-1:0]          r_w    [0:NSTEP];

    sct_pkg::pp_t           spp_reg   [0:NSTEP-1];
    sct_pkg::pp_t           cpp_reg   [0:NSTEP-1];
    logic [95:0]            sprod_reg [0:NSTEP-1];
    logic [95:0]            cprod_reg [0:NSTEP-1];
    logic                   sneg_reg  [0:NSTEP-1];
    logic                   cneg_reg  [0:NSTEP-1];
    logic signed [47:0]     sacc_reg  [0:NSTEP-1];
    logic signed [47:0]     cacc_reg  [0:NSTEP-1];
    logic [47:0]            x2a_reg   [0:NSTEP-1];
    logic [47:0]            x2b_reg   [0:NSTEP-1];
    logic [47:0]            x2c_reg   [0:NSTEP-1];
    logic [RW-1:0]          ra_reg    [0:NSTEP-1];
    logic [RW-1:0]          rb_reg    [0:NSTEP-1];
    logic [RW-1:0]          rc_reg    [0:NSTEP-1];

    sct_pkg::pp_t           fpp_reg;
    logic [95:0]            fprod_reg;
    logic                   fneg_reg;
    logic signed [47:0]     fsin_reg;
    logic signed [47:0]     fcos_a_reg;
    logic signed [47:0]     fcos_b_reg;
    logic signed [47:0]     fcos_c_reg;
    logic [31:0]            psin_reg;
    logic [31:0]            pcos_reg;

    logic                   res_valid_reg;
    logic                   res_valid_next;
    logic [31:0]            res_sin_reg;
    logic [31:0]            res_sin_next;
    logic [31:0]            res_cos_reg;
    logic [31:0]            res_cos_next;
    logic                   skid_valid_reg;
    logic                   skid_valid_next;
    logic [31:0]            skid_sin_reg;
    logic [31:0]            skid_sin_next;
    logic [31:0]            skid_cos_reg;
    logic [31:0]            skid_cos_next;

    // The pipeline moves as a whole whenever the skid register is free.
    assign adv = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], angle_valid};
        end
    end

    // Range reduction: shift into positive range, then subtract 8, 4, 2 and
    // 1 times 2*pi where they fit.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            red_reg[0] <= {angle[31], angle} + sct_pkg::RED_OFFSET;
        end
    end

    for (genvar i = 0; i < sct_pkg::RED_STEPS; i++)
    begin : g_red
        localparam logic [sct_pkg::RED_WIDTH-1:0] MULT =
            sct_pkg::TWO_PI_Q26 << (sct_pkg::RED_STEPS - 1 - i);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                red_reg[i+1] <= (red_reg[i] >= MULT) ? red_reg[i] - MULT : red_reg[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r5_reg <= red_reg[sct_pkg::RED_STEPS][RW-1:0];
            rr_reg <= (2*RW)'(red_reg[sct_pkg::RED_STEPS][RW-1:0])
                      * (2*RW)'(red_reg[sct_pkg::RED_STEPS][RW-1:0]);
            x2_reg <= 48'((rr_reg + (2*RW)'(2048)) >> 12);
            r6_reg <= r5_reg;
        end
    end

    assign sacc_w[0] = $signed(sct_pkg::RECIP_FACT[2*NSTEP+1]);
    assign cacc_w[0] = $signed(sct_pkg::RECIP_FACT[2*NSTEP]);
    assign x2_w[0]   = x2_reg;
    assign r_w[0]    = r6_reg;

    // Each step: acc = c - x2*acc, as partial products, product sum, then
    // rounding, saturation and the subtraction.
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_step
        localparam int SPOW = 2 * (NSTEP - 1 - j) + 1;
        localparam int CPOW = 2 * (NSTEP - 1 - j);
        localparam logic signed [49:0] SCOEF = $signed({2'b00, sct_pkg::RECIP_FACT[SPOW]});
        localparam logic signed [49:0] CCOEF = $signed({2'b00, sct_pkg::RECIP_FACT[CPOW]});

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                spp_reg[j]   <= sct_pkg::pp_calc(x2_w[j], sct_pkg::mag48(sacc_w[j]),
                                                 sacc_w[j][47]);
                cpp_reg[j]   <= sct_pkg::pp_calc(x2_w[j], sct_pkg::mag48(cacc_w[j]),
                                                 cacc_w[j][47]);
                x2a_reg[j]   <= x2_w[j];
                ra_reg[j]    <= r_w[j];

                sprod_reg[j] <= sct_pkg::pp_sum(spp_reg[j]);
                cprod_reg[j] <= sct_pkg::pp_sum(cpp_reg[j]);
                sneg_reg[j]  <= spp_reg[j].neg;
                cneg_reg[j]  <= cpp_reg[j].neg;
                x2b_reg[j]   <= x2a_reg[j];
                rb_reg[j]    <= ra_reg[j];

                sacc_reg[j]  <= sct_pkg::sat48(SCOEF
                                - 50'(sct_pkg::mul_finish(sprod_reg[j], sneg_reg[j])));
                cacc_reg[j]  <= sct_pkg::sat48(CCOEF
                                - 50'(sct_pkg::mul_finish(cprod_reg[j], cneg_reg[j])));
                x2c_reg[j]   <= x2b_reg[j];
                rc_reg[j]    <= rb_reg[j];
            end
        end

        assign sacc_w[j+1] = sacc_reg[j];
        assign cacc_w[j+1] = cacc_reg[j];
        assign x2_w[j+1]   = x2c_reg[j];
        assign r_w[j+1]    = rc_reg[j];
    end

    // Sine is x times the odd-series sum, with x = r in Q8.40; cosine waits.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fpp_reg    <= sct_pkg::pp_calc({5'b0, r_w[NSTEP], 14'b0},
                                           sct_pkg::mag48(sacc_w[NSTEP]),
                                           sacc_w[NSTEP][47]);
            fcos_a_reg <= cacc_w[NSTEP];
            fprod_reg  <= sct_pkg::pp_sum(fpp_reg);
            fneg_reg   <= fpp_reg.neg;
            fcos_b_reg <= fcos_a_reg;
            fsin_reg   <= sct_pkg::mul_finish(fprod_reg, fneg_reg);
            fcos_c_reg <= fcos_b_reg;
            psin_reg   <= sct_pkg::to_q29(fsin_reg);
            pcos_reg   <= sct_pkg::to_q29(fcos_c_reg);
        end
    end

    // Output register with a one-beat skid behind it.
    always_comb
    begin
        res_valid_next  = res_valid_reg;
        res_sin_next    = res_sin_reg;
        res_cos_next    = res_cos_reg;
        skid_valid_next = skid_valid_reg;
        skid_sin_next   = skid_sin_reg;
        skid_cos_next   = skid_cos_reg;
        if (!res_valid_reg || !result_stall)
        begin
            if (skid_valid_reg)
            begin
                res_valid_next  = 1'b1;
                res_sin_next    = skid_sin_reg;
                res_cos_next    = skid_cos_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                res_valid_next = vld_reg[DEPTH-1];
                res_sin_next   = psin_reg;
                res_cos_next   = pcos_reg;
            end
        end
        else if (!skid_valid_reg && vld_reg[DEPTH-1])
        begin
            skid_valid_next = 1'b1;
            skid_sin_next   = psin_reg;
            skid_cos_next   = pcos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg  <= res_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_sin_reg  <= res_sin_next;
        res_cos_reg  <= res_cos_next;
        skid_sin_reg <= skid_sin_next;
        skid_cos_reg <= skid_cos_next;
    end

    assign angle_stall  = skid_valid_reg;
    assign result_valid = res_valid_reg;
    assign sine         = res_sin_reg;
    assign cosine       = res_cos_reg;

endmodule

// ===== design/sct_checker.sv =====
// ============================================================================
// sct_checker: port-level checks for the series sine/cosine unit
// Watches the handshakes and the stall behavior of the top level.
// ============================================================================
module sct_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        angle_stall,
    input logic        result_valid,
    input logic        result_stall,
    input logic [31:0] sine,
    input logic [31:0] cosine
);

    // A stalled result beat stays valid.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result beat dropped while stalled");

    // A stalled result beat keeps its payload.
    a_result_stable: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(sine) && $stable(cosine))
        else $error("result payload changed while stalled");

    // The input side only stalls behind a waiting result beat.
    a_stall_needs_result: assert property (@(posedge clk) disable iff (!rst_n)
        angle_stall |-> result_valid)
        else $error("angle stalled with no result waiting");

    // The skid fills only while the receiver was stalling.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(angle_stall) |-> $past(result_valid && result_stall))
        else $error("angle stall rose without a stalled result");

endmodule

bind sin_cos_taylor_series_unit sct_checker u_sct_checker (.*);
